[rtl/core/modular_exponentiation_macros.svh]
// Assertion macros used by the checker file.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Check on every rising clock edge outside reset.
`define ME_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked from the next edge.
`define ME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/me_pkg.sv]
// Package: widths, operand bundle and modular add helper.
`timescale 1ns / 1ps
package me_pkg;
  localparam int WIDTH = 64;

  typedef struct packed {
    logic [WIDTH-1:0] a_acc;
    logic [WIDTH-1:0] a_sq;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] n;
  } me_opnd_t;

  // (x + y) mod n for x, y < n, keeping the carry.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] n);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[WIDTH-1:0];
  endfunction
endpackage

[rtl/core/me_cell.sv]
// One shift-add reduce step for the accumulator and square lanes.
`timescale 1ns / 1ps
module me_cell import me_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_racc,
  input  logic [WIDTH-1:0] in_rsq,
  input  me_opnd_t         ops,
  input  logic             b_bit,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_racc,
  output logic [WIDTH-1:0] out_rsq
);
  logic [WIDTH-1:0] racc_next, rsq_next, dacc, dsq;

  always_comb begin
    dacc = add_mod(in_racc, in_racc, ops.n);
    dsq  = add_mod(in_rsq, in_rsq, ops.n);
    racc_next = b_bit ? add_mod(dacc, ops.a_acc, ops.n) : dacc;
    rsq_next  = b_bit ? add_mod(dsq, ops.a_sq, ops.n) : dsq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_racc <= racc_next;
    out_rsq  <= rsq_next;
  end
endmodule

[rtl/core/me_chain.sv]
// Row of reduce cells; cell k consumes multiplier bit WIDTH-1-k.
`timescale 1ns / 1ps
module me_chain import me_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  me_opnd_t         ops,
  output logic             done,
  output logic [WIDTH-1:0] prod_acc,
  output logic [WIDTH-1:0] prod_sq
);
  logic             v    [0:WIDTH];
  logic [WIDTH-1:0] racc [0:WIDTH];
  logic [WIDTH-1:0] rsq  [0:WIDTH];

  assign v[0]    = start;
  assign racc[0] = '0;
  assign rsq[0]  = '0;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    me_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v[k]), .in_racc(racc[k]), .in_rsq(rsq[k]),
      .ops(ops), .b_bit(ops.b[WIDTH-1-k]),
      .out_valid(v[k+1]), .out_racc(racc[k+1]), .out_rsq(rsq[k+1])
    );
  end

  assign done     = v[WIDTH];
  assign prod_acc = racc[WIDTH];
  assign prod_sq  = rsq[WIDTH];
endmodule

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation by right-to-left square and multiply over a cell row.
// An item first reduces the base mod n, then takes one pass per exponent
// bit up to the highest set bit. Each pass goes through the row of WIDTH
// reduce cells, through which the multiply and the square pass together.
// One item is in work at a time; a zero modulus returns result 0 with
// error set in the cycle after it is accepted.
`timescale 1ns / 1ps
module modular_exponentiation import me_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] base,
  input  logic [WIDTH-1:0] exponent,
  input  logic [WIDTH-1:0] modulus,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] result,
  output logic             error
);
  typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_CHECK, S_MUL, S_DONE} state_t;

  state_t           state;
  me_opnd_t         ops;
  logic             launch, done;
  logic [WIDTH-1:0] acc, sq, e, prod_acc, prod_sq;

  me_chain u_chain (
    .clk(clk), .rst(rst), .start(launch), .ops(ops),
    .done(done), .prod_acc(prod_acc), .prod_sq(prod_sq)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            e       <= exponent;
            acc     <= WIDTH'(1);
            ops.n   <= modulus;
            ops.a_acc <= WIDTH'(1);
            ops.a_sq  <= WIDTH'(1);
            ops.b   <= base;
            if (modulus == '0) begin
              result <= '0;
              error  <= 1'b1;
              state  <= S_DONE;
            end else begin
              launch <= 1'b1;
              state  <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          // base mod n comes out of the accumulator lane
          if (done) begin
            sq    <= prod_acc;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (e == '0) begin
            result <= acc;
            error  <= 1'b0;
            state  <= S_DONE;
          end else begin
            ops.a_acc <= acc;
            ops.a_sq  <= sq;
            ops.b     <= sq;
            launch    <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (done) begin
            if (e[0]) acc <= prod_acc;
            sq    <= prod_sq;
            e     <= e >> 1;
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/me_checker.sv]
// Port-level checker for the modular exponentiation block, with its bind.
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"
module me_checker import me_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] result,
  input logic             error
);
  `ME_ASSERT_CLK(a_err_zero, clk, rst, !(out_valid && error) || (result == '0))
  `ME_ASSERT_CLK(a_one_item, clk, rst, !out_valid || in_stall)
  `ME_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ME_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result))
endmodule

bind modular_exponentiation me_checker u_me_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result(result), .error(error)
);
